// ----- rtl/core/hpq_pkg.sv -----
// Shared types and constants for the hourly profile quantizer.
// No dependencies; imported by hpq_level and hourly_profile_quantizer_unit.
package hpq_pkg;

  localparam int unsigned VAL_W    = 31;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEVEL_W  = 4;
  localparam int unsigned NUM_K_W  = 11;
  localparam int unsigned DEN_K_W  = 7;
  localparam int unsigned NUM_W    = VAL_W + NUM_K_W;
  localparam int unsigned DEN_W    = VAL_W + DEN_K_W;
  localparam int unsigned STEP_W   = 2;

  localparam logic [NUM_K_W-1:0] LEVEL_NUM = 11'd1485;
  localparam logic [DEN_K_W-1:0] LEVEL_DEN = 7'd100;

  localparam logic [BYTE_W-1:0] HI_NIBBLE_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LO_NIBBLE_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] PRESENCE_BIT   = 8'h01;

  typedef enum logic {
    MODE_LEVEL    = 1'b0,
    MODE_PRESENCE = 1'b1
  } profile_mode_e;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] max;
  } lvl_req_t;

  typedef struct packed {
    logic               done;
    logic [LEVEL_W-1:0] level;
  } lvl_rsp_t;

endpackage

// ----- rtl/core/hpq_level.sv -----
// Level unit: forms v*1485 and max*100, then a 4-step restoring division.
// Depends on hpq_pkg (widths, constants, request/response structs).
module hpq_level (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hpq_pkg::lvl_req_t req_i,
  output hpq_pkg::lvl_rsp_t rsp_o
);
  import hpq_pkg::*;

  logic                active_q, active_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                done_q, done_d;
  logic [NUM_W-1:0]    num_q, num_d;
  logic [NUM_W-1:0]    den_q, den_d;
  logic [LEVEL_W-1:0]  quo_q, quo_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic                zero_q, zero_d;
  logic                ge;
  logic [LEVEL_W-1:0]  quo_next;
  logic [DEN_W-1:0]    den_full;

  assign ge       = (num_q >= den_q);
  assign quo_next = {quo_q[LEVEL_W-2:0], ge};
  assign den_full = DEN_W'(req_i.max) * DEN_W'(LEVEL_DEN);

  always_comb begin
    active_d = active_q;
    step_d   = step_q;
    done_d   = 1'b0;
    num_d    = num_q;
    den_d    = den_q;
    quo_d    = quo_q;
    level_d  = level_q;
    zero_d   = zero_q;
    if (req_i.start) begin
      // Load operands; the divisor starts aligned to the top quotient bit.
      active_d = 1'b1;
      step_d   = '1;
      num_d    = NUM_W'(req_i.value) * NUM_W'(LEVEL_NUM);
      den_d    = NUM_W'({den_full, 3'b000});
      quo_d    = '0;
      zero_d   = (req_i.value == '0);
    end else if (active_q) begin
      if (ge) begin
        num_d = num_q - den_q;
      end
      den_d  = den_q >> 1;
      quo_d  = quo_next;
      step_d = step_q - STEP_W'(1);
      if (step_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
        level_d  = zero_q ? '0 : LEVEL_W'(quo_next + LEVEL_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      step_q   <= '0;
      done_q   <= 1'b0;
    end else begin
      active_q <= active_d;
      step_q   <= step_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q   <= num_d;
    den_q   <= den_d;
    quo_q   <= quo_d;
    level_q <= level_d;
    zero_q  <= zero_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.level = level_q;

endmodule

// ----- rtl/core/hourly_profile_quantizer_unit.sv -----
// Top level of the hourly profile quantizer: hour store memory and sequencer.
// Depends on hpq_pkg and instantiates hpq_level.
//
// Hours are transferred one per cycle (start high while busy is low) and are
// written into an on-chip store of HOURS entries while the frame maximum is
// tracked (it starts at 1). The transfer of the last hour of a frame raises
// busy and the block walks the store, one synchronous read per hour. In level
// mode each hour passes through read, evaluate, operand load plus four
// quotient steps of the shared level unit, and result; in presence mode
// it passes only through read and evaluate. The walk over the single read
// port and the bit-per-cycle divider set the pace, and within a frame the
// hours are taken back to back. Each packed byte appears on profile_byte_o
// for exactly one cycle with result_strobe_o high; last_byte_o marks the
// final byte. There is no backpressure: the receiver must take every byte
// on the cycle it is shown. profile_mode is written over the config channel
// (always ready) and is read while the profile is built. The store needs no
// clearing pass: every entry is rewritten in each frame.
module hourly_profile_quantizer_unit #(
  parameter int unsigned HOURS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [hpq_pkg::VAL_W-1:0]    hour_value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_data_i,
  output logic                         result_strobe_o,
  output logic [hpq_pkg::BYTE_W-1:0]   profile_byte_o,
  output logic                         last_byte_o
);
  import hpq_pkg::*;

  localparam int unsigned CNT_W = $clog2(HOURS);
  localparam logic [CNT_W-1:0] LAST_HOUR = CNT_W'(HOURS - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_EVAL = 4'b0100,
    ST_DIV  = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [VAL_W-1:0]   max_q, max_d;
  profile_mode_e      mode_q;
  logic [BYTE_W-1:0]  byte_q, byte_d;
  logic               strobe_q, strobe_d;
  logic               last_q, last_d;
  logic [BYTE_W-1:0]  out_byte_q;

  logic [VAL_W-1:0]   store_mem [HOURS];
  logic [VAL_W-1:0]   rd_data_q;
  logic               store_we;

  lvl_req_t           lvl_req;
  lvl_rsp_t           lvl_rsp;

  logic               hour_done;
  logic               at_last;
  logic               byte_end;
  logic [BYTE_W-1:0]  byte_new;
  logic [BYTE_W-1:0]  bit_mask;
  logic [2:0]         bit_pos;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign at_last     = (idx_q == LAST_HOUR);
  assign bit_pos     = idx_q[2:0];
  assign bit_mask    = (rd_data_q != '0) ? (PRESENCE_BIT << (3'd7 - bit_pos)) : '0;

  // Merge this hour into the byte under construction.
  always_comb begin
    if (mode_q == MODE_PRESENCE) begin
      byte_new = ((bit_pos == '0) ? '0 : byte_q) | bit_mask;
      byte_end = (bit_pos == 3'd7) || at_last;
    end else begin
      if (idx_q[0] == 1'b0) begin
        byte_new = {lvl_rsp.level, 4'h0} & HI_NIBBLE_MASK;
      end else begin
        byte_new = (byte_q & HI_NIBBLE_MASK) | (BYTE_W'(lvl_rsp.level) & LO_NIBBLE_MASK);
      end
      byte_end = idx_q[0] || at_last;
    end
  end

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    max_d         = max_q;
    byte_d        = byte_q;
    strobe_d      = 1'b0;
    last_d        = last_q;
    store_we      = 1'b0;
    hour_done     = 1'b0;
    lvl_req.start = 1'b0;
    lvl_req.value = rd_data_q;
    lvl_req.max   = max_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          // Store the hour and track the frame maximum.
          store_we = 1'b1;
          if (hour_value_i > max_q) begin
            max_d = hour_value_i;
          end
          if (at_last) begin
            idx_d   = '0;
            state_d = ST_READ;
          end else begin
            idx_d = idx_q + CNT_W'(1);
          end
        end
      end
      ST_READ: begin
        // Read data for idx_q lands in rd_data_q at this edge.
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (mode_q == MODE_PRESENCE) begin
          hour_done = 1'b1;
        end else begin
          lvl_req.start = 1'b1;
          state_d       = ST_DIV;
        end
      end
      ST_DIV: begin
        if (lvl_rsp.done) begin
          hour_done = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (hour_done) begin
      byte_d = byte_new;
      if (byte_end) begin
        strobe_d = 1'b1;
        last_d   = at_last;
      end
      if (at_last) begin
        // Frame done: rewind and restart the maximum.
        idx_d   = '0;
        max_d   = VAL_W'(1);
        state_d = ST_IDLE;
      end else begin
        idx_d   = idx_q + CNT_W'(1);
        state_d = ST_READ;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      max_q    <= VAL_W'(1);
      mode_q   <= MODE_LEVEL;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      max_q    <= max_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        mode_q <= profile_mode_e'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    if (strobe_d) begin
      out_byte_q <= byte_d;
    end
  end

  // Hour store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[idx_q] <= hour_value_i;
    end
    rd_data_q <= store_mem[idx_q];
  end

  hpq_level u_level (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (lvl_req),
    .rsp_o  (lvl_rsp)
  );

  assign result_strobe_o = strobe_q;
  assign profile_byte_o  = out_byte_q;
  assign last_byte_o     = last_q;

`ifndef SYNTHESIS
  a_strobe_from_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_DIV))
    else $error("result strobe without a profile walk");

  a_last_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_q && last_q) |-> (state_q == ST_IDLE && idx_q == '0))
    else $error("final byte while the walk is still running");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_rsp.done |-> (state_q == ST_DIV))
    else $error("level result outside the divide wait");

  a_max_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q != '0)
    else $error("frame maximum is zero");

  a_no_write_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_we |-> (state_q == ST_IDLE))
    else $error("store written during the profile walk");
`endif

endmodule

// ----- sim/hourly_profile_quantizer_unit_tb.sv -----
// Self-checking testbench for hourly_profile_quantizer_unit.
// Depends on hpq_pkg and the unit itself; a scoreboard class predicts each
// packed profile from the hours sent and checks every byte the block emits.
module hourly_profile_quantizer_unit_tb;

  import hpq_pkg::*;

  localparam int unsigned HOURS         = 24;
  localparam int unsigned RANDOM_FRAMES = 4;
  // While a frame is emitted a byte comes out for every two level hours or
  // eight presence hours, so any long silence means the block has hung.
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned IDLE_PAUSE    = 20;
  localparam int unsigned DRAIN_CYCLES  = 30;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Flavors of random frame content.
  typedef enum int unsigned {
    FRAME_WIDE,    // any magnitude, bits thinned by a random shift
    FRAME_SPARSE,  // about half the hours empty
    FRAME_SMALL,   // tiny counts, so levels split finely around a small max
    FRAME_ZERO     // nothing consumed at all
  } frame_kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } profile_entry_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              start        = 1'b0;
  logic              busy;
  logic [VAL_W-1:0]  hour_value_i = '0;
  logic              cfg_valid_i  = 1'b0;
  logic              cfg_ready_o;
  logic              cfg_data_i   = 1'b0;
  logic              result_strobe_o;
  logic [BYTE_W-1:0] profile_byte_o;
  logic              last_byte_o;

  // Scoreboard: rebuilds the frame, quantizes it once the last hour is in,
  // and queues the bytes the block owes.
  class profile_scoreboard;
    logic [VAL_W-1:0] frame_hours[$];
    logic [VAL_W-1:0] frame_max;
    profile_mode_e    mode;
    profile_entry_t   profile_bytes_due[$];
    int unsigned      bytes_checked;
    int unsigned      failures;
    int unsigned      level_frames;
    int unsigned      presence_frames;

    function new();
      frame_max = 1;
      mode      = MODE_LEVEL;
    endfunction

    function void set_mode(profile_mode_e m);
      mode = m;
    endfunction

    function int unsigned pending();
      return profile_bytes_due.size();
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("mismatch: %s", msg);
    endfunction

    function logic [LEVEL_W-1:0] level_of_hour(logic [VAL_W-1:0] v);
      longint unsigned num;
      longint unsigned den;
      if (v == '0) return '0;
      // Form the product exactly, 42 bits wide.
      num = v;
      num = num * LEVEL_NUM;
      den = frame_max;
      den = den * LEVEL_DEN;
      return LEVEL_W'(num / den + 1);
    endfunction

    function void quantize_frame();
      logic [BYTE_W-1:0] data;
      profile_entry_t    entry;
      int unsigned       nbytes;
      int unsigned       k;
      int unsigned       j;
      int unsigned       h;
      if (mode == MODE_LEVEL) begin
        // Earlier hour in the high nibble; an odd last hour leaves the low one 0.
        nbytes = (HOURS + 1) / 2;
        for (k = 0; k < nbytes; k++) begin
          data = '0;
          data[BYTE_W-1 -: LEVEL_W] = level_of_hour(frame_hours[2*k]);
          if (2*k + 1 < HOURS) data[LEVEL_W-1:0] = level_of_hour(frame_hours[2*k+1]);
          entry.data = data;
          entry.last = (k + 1 == nbytes);
          profile_bytes_due.push_back(entry);
        end
        level_frames++;
      end else begin
        // One bit per hour, earliest in the MSB; unused tail bits stay 0.
        nbytes = (HOURS + 7) / 8;
        for (k = 0; k < nbytes; k++) begin
          data = '0;
          for (j = 0; j < 8; j++) begin
            h = k*8 + j;
            if (h < HOURS && frame_hours[h] != '0) data |= PRESENCE_BIT << (BYTE_W - 1 - j);
          end
          entry.data = data;
          entry.last = (k + 1 == nbytes);
          profile_bytes_due.push_back(entry);
        end
        presence_frames++;
      end
      frame_hours.delete();
      frame_max = 1;
    endfunction

    function void note_hour(logic [VAL_W-1:0] v);
      frame_hours.push_back(v);
      if (v > frame_max) frame_max = v;
      if (frame_hours.size() == HOURS) quantize_frame();
    endfunction

    function void check_byte(logic [BYTE_W-1:0] data, logic last);
      profile_entry_t due;
      if (profile_bytes_due.size() == 0) begin
        note_failure($sformatf("unexpected byte %02h last %0b", data, last));
        return;
      end
      due = profile_bytes_due.pop_front();
      bytes_checked++;
      if (data !== due.data)
        note_failure($sformatf("byte %0d: profile_byte expected %02h got %02h",
                               bytes_checked, due.data, data));
      if (last !== due.last)
        note_failure($sformatf("byte %0d: last_byte expected %0b got %0b",
                               bytes_checked, due.last, last));
    endfunction
  endclass

  profile_scoreboard sb = new();

  // Directed frame: range extremes, single bits, alternating patterns and
  // scattered empty hours, all quantized against the full-scale maximum.
  localparam logic [VAL_W-1:0] DIRECTED_HOURS [HOURS] = '{
    31'h0000_0001, 31'h0000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFE,
    31'h4000_0000, 31'h3FFF_FFFF, 31'h2AAA_AAAA, 31'h5555_5555,
    31'h0000_FFFF, 31'h7FFF_0000, 31'h0000_0000, 31'h0F0F_0F0F,
    31'h70F0_F0F0, 31'h1000_0000, 31'h0800_0000, 31'h089A_BCDE,
    31'h0000_0000, 31'h0000_0002, 31'h7000_0000, 31'h6000_0000,
    31'h0C00_0000, 31'h0000_0000, 31'h7FFF_FFFF, 31'h0113_4567
  };

  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;

  hourly_profile_quantizer_unit #(
    .HOURS(HOURS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .hour_value_i   (hour_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_strobe_o(result_strobe_o),
    .profile_byte_o (profile_byte_o),
    .last_byte_o    (last_byte_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Take every byte on the cycle it is shown; the block cannot be stalled.
  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o) sb.check_byte(profile_byte_o, last_byte_o);
  end

  // Watchdog: count cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d bytes still due",
               STALL_LIMIT, sb.pending());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one hour and hold it until the block transfers it. The sender
  // works in bursts; between bursts drop start for a random gap.
  task automatic send_hour(input logic [VAL_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    start        <= 1'b1;
    hour_value_i <= v;
    do @(posedge clk_i); while (busy);
    sb.note_hour(v);
    burst_left--;
  endtask

  // Wait for the last frame's bytes plus a margin, then rewrite profile_mode.
  task automatic write_mode(input profile_mode_e m);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (IDLE_PAUSE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_mode(m);
  endtask

  function automatic logic [VAL_W-1:0] random_hour(frame_kind_e kind);
    logic [VAL_W-1:0] wide;
    wide = VAL_W'($urandom) >> $urandom_range(0, VAL_W - 1);
    case (kind)
      FRAME_WIDE:   return wide;
      FRAME_SPARSE: return ($urandom_range(0, 1) == 0) ? '0 : wide;
      FRAME_SMALL:  return VAL_W'($urandom_range(0, 20));
      default:      return '0;
    endcase
  endfunction

  initial begin
    int unsigned   f;
    int unsigned   h;
    frame_kind_e   kind;
    profile_mode_e m;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First frame runs in the reset mode, which must be level.
    for (h = 0; h < HOURS; h++) send_hour(DIRECTED_HOURS[h]);

    // Random frames: force one of each mode early and one all-empty frame.
    for (f = 0; f < RANDOM_FRAMES; f++) begin
      if (f == 0)      m = MODE_PRESENCE;
      else if (f == 1) m = MODE_LEVEL;
      else             m = profile_mode_e'($urandom_range(0, 1));
      write_mode(m);
      kind = (f == 2) ? FRAME_ZERO : frame_kind_e'($urandom_range(0, 2));
      for (h = 0; h < HOURS; h++) send_hour(random_hour(kind));
    end

    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // Linger so that any stray extra byte is caught.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.pending() != 0) sb.note_failure($sformatf("%0d bytes never arrived", sb.pending()));

    $display("covered %0d frames of %0d hours: %0d in level mode, %0d in presence mode",
             sb.level_frames + sb.presence_frames, HOURS, sb.level_frames,
             sb.presence_frames);
    $display("checked %0d profile bytes, %0d failures", sb.bytes_checked, sb.failures);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/hpq_pkg.sv
rtl/core/hpq_level.sv
rtl/core/hourly_profile_quantizer_unit.sv
sim/hourly_profile_quantizer_unit_tb.sv
